@@ hw/rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros used by ffua_ctrl
// Immediate-consequence and next-cycle implication checks, reset gated.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define FFUA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define FFUA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/ffua_pkg.sv @@
// ---------------------------------------------------------------------------
// ffua_pkg
// Types and fixed constants of the first-fit unit allocator.
// ---------------------------------------------------------------------------
package ffua_pkg;

   // Field widths of the request, response and register
   localparam int OP_W     = 1;
   localparam int OWNER_W  = 7;
   localparam int SIZE_W   = 11;
   localparam int STATUS_W = 3;
   localparam int START_W  = 10;
   localparam int FREE_W   = 11;
   localparam int TOTAL_W  = 11;

   // Owner map entry
   localparam int             MAP_W     = 8;
   localparam logic [MAP_W-1:0] UNIT_FREE = 8'hFF;

   // Register reset value and free count ceiling
   localparam int             TOTAL_RESET = 1024;
   localparam logic [FREE_W-1:0] FREE_MAX = 11'h7FF;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } ffua_op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_ALLOC   = 3'd0,
      STAT_NOFIT   = 3'd1,
      STAT_FREED   = 3'd2,
      STAT_NOTHOLD = 3'd3,
      STAT_BUSY    = 3'd4
   } ffua_status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DECIDE,
      S_SCAN,
      S_WRITE,
      S_FREE,
      S_DONE
   } ffua_state_type;

endpackage

@@ hw/rtl/ffua_if.sv @@
// ---------------------------------------------------------------------------
// ffua_req_if / ffua_rsp_if
// Valid/ready channels for allocator requests and responses.
// ---------------------------------------------------------------------------
interface ffua_req_if;
   import ffua_pkg::*;

   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     op;
   logic [OWNER_W-1:0]  owner_id;
   logic [SIZE_W-1:0]   request_size;

   modport source (output valid, output op, output owner_id, output request_size,
                   input ready);
   modport sink   (input valid, input op, input owner_id, input request_size,
                   output ready);
endinterface

interface ffua_rsp_if;
   import ffua_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [START_W-1:0]  start_unit;
   logic [FREE_W-1:0]   free_units;

   modport source (output valid, output status, output start_unit, output free_units,
                   input ready);
   modport sink   (input valid, input status, input start_unit, input free_units,
                   output ready);
endinterface

@@ hw/rtl/ffua_map_mem.sv @@
// ---------------------------------------------------------------------------
// ffua_map_mem
// Owner map: one entry per memory unit, one write and one registered read.
// ---------------------------------------------------------------------------
module ffua_map_mem #(
   parameter int DEPTH = 1024
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  logic [ffua_pkg::MAP_W-1:0]   wr_data,
   input  logic                         rd_en,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   output logic [ffua_pkg::MAP_W-1:0]   rd_data
);
   import ffua_pkg::*;

   logic [MAP_W-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

@@ hw/rtl/ffua_owner_tab.sv @@
// ---------------------------------------------------------------------------
// ffua_owner_tab
// Per-owner run start and length, one write and one registered read.
// ---------------------------------------------------------------------------
module ffua_owner_tab #(
   parameter int MAP_DEPTH  = 1024,
   parameter int MAX_OWNERS = 128
) (
   input  logic                                    clock,
   input  logic                                    rd_en,
   input  logic [$clog2((MAX_OWNERS < 128) ? MAX_OWNERS : 128)-1:0] rd_addr,
   output logic [$clog2(MAP_DEPTH)-1:0]            rd_start,
   output logic [ffua_pkg::SIZE_W-1:0]             rd_len,
   input  logic                                    wr_en,
   input  logic [$clog2((MAX_OWNERS < 128) ? MAX_OWNERS : 128)-1:0] wr_addr,
   input  logic [$clog2(MAP_DEPTH)-1:0]            wr_start,
   input  logic [ffua_pkg::SIZE_W-1:0]             wr_len
);
   import ffua_pkg::*;

   localparam int OWN_DEPTH = (MAX_OWNERS < (1 << OWNER_W)) ? MAX_OWNERS : (1 << OWNER_W);
   localparam int MAP_AW    = $clog2(MAP_DEPTH);

   logic [MAP_AW-1:0] start_mem [OWN_DEPTH];
   logic [SIZE_W-1:0] len_mem   [OWN_DEPTH];

   // Record a granted run
   always_ff @(posedge clock) begin
      if (wr_en) begin
         start_mem[wr_addr] <= wr_start;
         len_mem[wr_addr]   <= wr_len;
      end
   end

   // Registered lookup
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_start <= start_mem[rd_addr];
         rd_len   <= len_mem[rd_addr];
      end
   end
endmodule

@@ hw/rtl/ffua_step_unit.sv @@
// ---------------------------------------------------------------------------
// ffua_step_unit
// Shared walk unit: advances the unit counter and compares it to a limit.
// ---------------------------------------------------------------------------
module ffua_step_unit #(
   parameter int W = 11
) (
   input  logic [W-1:0] cur,
   input  logic [W-1:0] lim,
   output logic [W-1:0] nxt,
   output logic         below
);
   import ffua_pkg::*;

   // Increment and bound check
   assign nxt   = cur + W'(1);
   assign below = (cur < lim);
endmodule

@@ hw/rtl/ffua_ctrl.sv @@
// ---------------------------------------------------------------------------
// ffua_ctrl
// Sequencer: map clearing, first-fit scan, run write and release, response.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ffua_ctrl #(
   parameter int MAP_DEPTH  = 1024,
   parameter int MAX_OWNERS = 128
) (
   input  logic                                    clock,
   input  logic                                    reset,
   ffua_req_if.sink                                req,
   ffua_rsp_if.source                              rsp,
   input  logic                                    csr_wr_en,
   input  logic [ffua_pkg::TOTAL_W-1:0]            csr_wr_data,
   output logic                                    map_wr_en,
   output logic [$clog2(MAP_DEPTH)-1:0]            map_wr_addr,
   output logic [ffua_pkg::MAP_W-1:0]              map_wr_data,
   output logic                                    map_rd_en,
   output logic [$clog2(MAP_DEPTH)-1:0]            map_rd_addr,
   input  logic [ffua_pkg::MAP_W-1:0]              map_rd_data,
   output logic                                    tab_rd_en,
   output logic [$clog2((MAX_OWNERS < 128) ? MAX_OWNERS : 128)-1:0] tab_rd_addr,
   input  logic [$clog2(MAP_DEPTH)-1:0]            tab_rd_start,
   input  logic [ffua_pkg::SIZE_W-1:0]             tab_rd_len,
   output logic                                    tab_wr_en,
   output logic [$clog2((MAX_OWNERS < 128) ? MAX_OWNERS : 128)-1:0] tab_wr_addr,
   output logic [$clog2(MAP_DEPTH)-1:0]            tab_wr_start,
   output logic [ffua_pkg::SIZE_W-1:0]             tab_wr_len
);
   import ffua_pkg::*;

   localparam int MAP_AW    = $clog2(MAP_DEPTH);
   localparam int CNT_W     = (MAP_AW + 1 > SIZE_W) ? MAP_AW + 1 : SIZE_W;
   localparam int OWN_DEPTH = (MAX_OWNERS < (1 << OWNER_W)) ? MAX_OWNERS : (1 << OWNER_W);
   localparam int OWN_AW    = $clog2(OWN_DEPTH);
   localparam int TOTAL_RST = (MAP_DEPTH < TOTAL_RESET) ? MAP_DEPTH : TOTAL_RESET;
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(MAP_DEPTH);

   ffua_state_type        state_ff, state_in;
   logic [CNT_W-1:0]      total_ff, total_in;
   logic [CNT_W-1:0]      used_ff, used_in;
   logic [OWN_DEPTH-1:0]  holds_ff, holds_in;
   ffua_op_type           op_ff, op_in;
   logic [OWNER_W-1:0]    owner_ff, owner_in;
   logic [CNT_W-1:0]      size_ff, size_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [CNT_W-1:0]      end_ff, end_in;
   logic [CNT_W-1:0]      run_ff, run_in;
   logic [CNT_W-1:0]      run_start_ff, run_start_in;
   logic                  pend_ff, pend_in;
   logic [CNT_W-1:0]      chk_addr_ff, chk_addr_in;
   ffua_status_type       status_ff, status_in;
   logic [CNT_W-1:0]      start_ff, start_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   ffua_status_type       rsp_status_ff, rsp_status_in;
   logic [START_W-1:0]    rsp_start_ff, rsp_start_in;
   logic [FREE_W-1:0]     rsp_free_ff, rsp_free_in;

   logic                  req_fire;
   logic                  owner_ok;
   logic [OWN_AW-1:0]     own_idx;
   logic                  holds_cur;
   logic [CNT_W-1:0]      step_lim;
   logic [CNT_W-1:0]      step_nxt;
   logic                  step_below;
   logic [CNT_W-1:0]      run_inc;
   logic [CNT_W-1:0]      run_pos;
   logic [CNT_W-1:0]      csr_ext;
   logic [CNT_W-1:0]      free_diff;
   logic                  rsp_load;

   // Shared counter advance and bound compare
   ffua_step_unit #(.W(CNT_W)) u_step (
      .cur   (cnt_ff),
      .lim   (step_lim),
      .nxt   (step_nxt),
      .below (step_below)
   );

   assign req.ready  = (state_ff == S_IDLE);
   assign req_fire   = req.valid && req.ready;
   assign owner_ok   = (32'(owner_ff) < MAX_OWNERS);
   assign own_idx    = owner_ff[OWN_AW-1:0];
   assign holds_cur  = owner_ok && holds_ff[own_idx];
   assign run_inc    = run_ff + CNT_W'(1);
   assign run_pos    = (run_ff == '0) ? chk_addr_ff : run_start_ff;
   assign csr_ext    = CNT_W'(csr_wr_data);
   assign free_diff  = (total_ff > used_ff) ? (total_ff - used_ff) : '0;
   assign rsp_load   = (state_ff == S_DONE) && (!rsp_valid_ff || rsp.ready);

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.status     = rsp_status_ff;
   assign rsp.start_unit = rsp_start_ff;
   assign rsp.free_units = rsp_free_ff;

   // Owner table lookup issued with the accepted item
   assign tab_rd_en    = req_fire;
   assign tab_rd_addr  = req.owner_id[OWN_AW-1:0];
   assign tab_wr_addr  = own_idx;
   assign tab_wr_start = run_start_ff[MAP_AW-1:0];
   assign tab_wr_len   = size_ff[SIZE_W-1:0];

   // Select the limit for the shared compare
   always_comb begin
      case (state_ff)
         S_CLEAR:         step_lim = DEPTH_C;
         S_SCAN:          step_lim = total_ff;
         S_WRITE, S_FREE: step_lim = end_ff;
         default:         step_lim = '0;
      endcase
   end

   // Next state and datapath control
   always_comb begin
      state_in     = state_ff;
      total_in     = total_ff;
      used_in      = used_ff;
      holds_in     = holds_ff;
      op_in        = op_ff;
      owner_in     = owner_ff;
      size_in      = size_ff;
      cnt_in       = cnt_ff;
      end_in       = end_ff;
      run_in       = run_ff;
      run_start_in = run_start_ff;
      pend_in      = 1'b0;
      chk_addr_in  = chk_addr_ff;
      status_in    = status_ff;
      start_in     = start_ff;
      map_wr_en    = 1'b0;
      map_wr_addr  = cnt_ff[MAP_AW-1:0];
      map_wr_data  = UNIT_FREE;
      map_rd_en    = 1'b0;
      map_rd_addr  = cnt_ff[MAP_AW-1:0];
      tab_wr_en    = 1'b0;

      // Register write, saturated to the map depth
      if (csr_wr_en) begin
         total_in = (csr_ext > DEPTH_C) ? DEPTH_C : csr_ext;
      end

      unique case (state_ff)
         S_CLEAR: begin
            if (step_below) begin
               map_wr_en = 1'b1;
               cnt_in    = step_nxt;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               op_in    = ffua_op_type'(req.op);
               owner_in = req.owner_id;
               size_in  = CNT_W'(req.request_size);
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            start_in = '0;
            if (op_ff == OP_ALLOC) begin
               if (!owner_ok) begin
                  status_in = STAT_NOFIT;
                  state_in  = S_DONE;
               end else if (holds_cur) begin
                  status_in = STAT_BUSY;
                  state_in  = S_DONE;
               end else begin
                  cnt_in   = '0;
                  run_in   = '0;
                  state_in = S_SCAN;
               end
            end else begin
               if (!holds_cur) begin
                  status_in = STAT_NOTHOLD;
                  state_in  = S_DONE;
               end else begin
                  cnt_in   = CNT_W'(tab_rd_start);
                  end_in   = CNT_W'(tab_rd_start) + CNT_W'(tab_rd_len);
                  size_in  = CNT_W'(tab_rd_len);
                  state_in = S_FREE;
               end
            end
         end
         S_SCAN: begin
            // Issue the next read while the previous one is checked
            if (step_below) begin
               map_rd_en   = 1'b1;
               cnt_in      = step_nxt;
               pend_in     = 1'b1;
               chk_addr_in = cnt_ff;
            end
            if (pend_ff) begin
               if (map_rd_data == UNIT_FREE) begin
                  run_in       = run_inc;
                  run_start_in = run_pos;
                  if (run_inc >= size_ff) begin
                     pend_in  = 1'b0;
                     cnt_in   = run_pos;
                     end_in   = run_pos + size_ff;
                     state_in = S_WRITE;
                  end
               end else begin
                  run_in = '0;
               end
            end else if (!step_below) begin
               status_in = STAT_NOFIT;
               state_in  = S_DONE;
            end
         end
         S_WRITE: begin
            if (step_below) begin
               map_wr_en   = 1'b1;
               map_wr_data = MAP_W'(owner_ff);
               cnt_in      = step_nxt;
            end else begin
               tab_wr_en         = 1'b1;
               holds_in[own_idx] = 1'b1;
               used_in           = used_ff + size_ff;
               status_in         = STAT_ALLOC;
               start_in          = run_start_ff;
               state_in          = S_DONE;
            end
         end
         S_FREE: begin
            if (step_below) begin
               map_wr_en = 1'b1;
               cnt_in    = step_nxt;
            end else begin
               holds_in[own_idx] = 1'b0;
               used_in           = (used_ff > size_ff) ? (used_ff - size_ff) : '0;
               status_in         = STAT_FREED;
               state_in          = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register: load a finished item, drop it once taken
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_free_in   = rsp_free_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_start_in  = start_ff[START_W-1:0];
         rsp_free_in   = (free_diff > CNT_W'(FREE_MAX)) ? FREE_MAX
                                                        : free_diff[FREE_W-1:0];
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         total_ff     <= CNT_W'(TOTAL_RST);
         used_ff      <= '0;
         holds_ff     <= '0;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         used_ff      <= used_in;
         holds_ff     <= holds_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Item payload and working registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      owner_ff      <= owner_in;
      size_ff       <= size_in;
      end_ff        <= end_in;
      run_ff        <= run_in;
      run_start_ff  <= run_start_in;
      chk_addr_ff   <= chk_addr_in;
      status_ff     <= status_in;
      start_ff      <= start_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_free_ff   <= rsp_free_in;
   end

   // Checks
   `FFUA_ASSERT_NXT(a_busy_after_accept, clock, reset, req_fire, !req.ready, "ready stayed high after accept")
   `FFUA_ASSERT_IMP(a_scan_in_range, clock, reset, pend_ff, chk_addr_ff < total_ff, "scan checked a unit beyond the limit")
   `FFUA_ASSERT_IMP(a_write_owner_free, clock, reset, state_ff == S_WRITE, !holds_cur, "writing a run for an owner that already holds one")
   `FFUA_ASSERT_IMP(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff == S_DONE), "response raised outside completion")
endmodule

@@ hw/rtl/first_fit_unit_allocator_unit.sv @@
// ---------------------------------------------------------------------------
// first_fit_unit_allocator_unit
// First-fit contiguous allocator of memory units with an owner table.
// ---------------------------------------------------------------------------
// Usage:
//   req_if  : op (0 allocate, 1 free), owner_id, request_size; valid/ready.
//   rsp_if  : status, start_unit, free_units; one response per request.
//   csr_*   : csr_wr_en/csr_wr_data write total_units; write only when idle.
// After reset the owner map is swept to free, one unit a cycle, and
// req_if.ready stays low meanwhile.
// One request at a time. An allocate scans the map one unit per cycle
// through its single read port, then writes the granted run one unit
// per cycle. A free rewrites the run as free through the map write port.
// Requests refused at the owner check end without a map access.
// Responses sit in an output register; a new request is taken while a
// response waits, but the next response is held until rsp_if.ready.
// ---------------------------------------------------------------------------
module first_fit_unit_allocator_unit #(
   parameter int MAP_DEPTH  = 1024,
   parameter int MAX_OWNERS = 128
) (
   input  logic                          clock,
   input  logic                          reset,
   ffua_req_if.sink                      req_if,
   ffua_rsp_if.source                    rsp_if,
   input  logic                          csr_wr_en,
   input  logic [ffua_pkg::TOTAL_W-1:0]  csr_wr_data
);
   import ffua_pkg::*;

   localparam int MAP_AW    = $clog2(MAP_DEPTH);
   localparam int OWN_DEPTH = (MAX_OWNERS < (1 << OWNER_W)) ? MAX_OWNERS : (1 << OWNER_W);
   localparam int OWN_AW    = $clog2(OWN_DEPTH);

   logic              map_wr_en;
   logic [MAP_AW-1:0] map_wr_addr;
   logic [MAP_W-1:0]  map_wr_data;
   logic              map_rd_en;
   logic [MAP_AW-1:0] map_rd_addr;
   logic [MAP_W-1:0]  map_rd_data;
   logic              tab_rd_en;
   logic [OWN_AW-1:0] tab_rd_addr;
   logic [MAP_AW-1:0] tab_rd_start;
   logic [SIZE_W-1:0] tab_rd_len;
   logic              tab_wr_en;
   logic [OWN_AW-1:0] tab_wr_addr;
   logic [MAP_AW-1:0] tab_wr_start;
   logic [SIZE_W-1:0] tab_wr_len;

   // Sequencer
   ffua_ctrl #(.MAP_DEPTH(MAP_DEPTH), .MAX_OWNERS(MAX_OWNERS)) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req          (req_if),
      .rsp          (rsp_if),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .map_wr_en    (map_wr_en),
      .map_wr_addr  (map_wr_addr),
      .map_wr_data  (map_wr_data),
      .map_rd_en    (map_rd_en),
      .map_rd_addr  (map_rd_addr),
      .map_rd_data  (map_rd_data),
      .tab_rd_en    (tab_rd_en),
      .tab_rd_addr  (tab_rd_addr),
      .tab_rd_start (tab_rd_start),
      .tab_rd_len   (tab_rd_len),
      .tab_wr_en    (tab_wr_en),
      .tab_wr_addr  (tab_wr_addr),
      .tab_wr_start (tab_wr_start),
      .tab_wr_len   (tab_wr_len)
   );

   // Owner map
   ffua_map_mem #(.DEPTH(MAP_DEPTH)) u_map (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data),
      .rd_en   (map_rd_en),
      .rd_addr (map_rd_addr),
      .rd_data (map_rd_data)
   );

   // Owner run table
   ffua_owner_tab #(.MAP_DEPTH(MAP_DEPTH), .MAX_OWNERS(MAX_OWNERS)) u_tab (
      .clock    (clock),
      .rd_en    (tab_rd_en),
      .rd_addr  (tab_rd_addr),
      .rd_start (tab_rd_start),
      .rd_len   (tab_rd_len),
      .wr_en    (tab_wr_en),
      .wr_addr  (tab_wr_addr),
      .wr_start (tab_wr_start),
      .wr_len   (tab_wr_len)
   );
endmodule
